FILE: hdl/bpcr_pkg.sv
`default_nettype none
package bpcr_pkg;
  localparam int unsigned PoolFrames = 64;
  localparam int unsigned PinBits = 16;
  localparam int unsigned FrameBits = $clog2(PoolFrames);
  localparam int unsigned CountBits = $clog2(PoolFrames + 1);
  localparam int unsigned CheckBits = $clog2(2 * PoolFrames + 2);
  localparam int unsigned MaxChecks = 2 * PoolFrames + 1;
  localparam logic [2:0] UsageCap = 3'd5;

  typedef enum logic [2:0] {
    ST_HIT = 3'd0,
    ST_MISS_FREE = 3'd1,
    ST_MISS_EVICT = 3'd2,
    ST_EXHAUSTED = 3'd3,
    ST_UNPINNED = 3'd4,
    ST_UNKNOWN = 3'd5
  } status_e;

  typedef enum logic {
    ACT_FETCH = 1'b0,
    ACT_UNPIN = 1'b1
  } action_e;

  typedef struct packed {
    logic action;
    logic [31:0] rel_number;
    logic [31:0] block_number;
    logic set_dirty;
  } req_t;

  typedef struct packed {
    logic [5:0] frame;
    logic [2:0] status;
    logic load_needed;
    logic writeback_needed;
    logic [31:0] writeback_rel;
    logic [31:0] writeback_block;
  } rsp_t;

  typedef struct packed {
    logic valid;
    logic dirty;
    logic [PinBits-1:0] pins;
    logic [2:0] usage;
  } meta_t;
endpackage
`default_nettype wire

FILE: hdl/buffer_pool_clock_replacement.sv
// The tag scan reads one tag per cycle across all PoolFrames frames.
// A hit or unpin then updates the frame's metadata before its result; a miss into a free
// frame or an unknown tag goes straight to the result; a miss with no free frame sweeps
// the clock hand and ends in an eviction or, after 2*PoolFrames + 1 checks, in exhaustion.
// One request at a time; the next is taken once the result transfer completes.
// Reset clears the valid bits, the hand and the handout count; tags stay undefined.
`default_nettype none
module buffer_pool_clock_replacement
  import bpcr_pkg::*;
(
  input  wire logic clk_i,
  input  wire logic rst_ni,
  input  wire logic in_valid_i,
  output logic in_ready_o,
  input  wire req_t in_data_i,
  output logic out_valid_o,
  input  wire logic out_ready_i,
  output rsp_t out_data_o
);
  typedef enum logic [6:0] {
    S_IDLE = 7'b0000001,
    S_SCAN = 7'b0000010,
    S_META = 7'b0000100,
    S_UPD = 7'b0001000,
    S_SWP = 7'b0010000,
    S_VIC = 7'b0100000,
    S_OUT = 7'b1000000
  } state_e;

  logic [63:0] tag_mem [PoolFrames];
  meta_t meta_mem [PoolFrames];
  logic [PoolFrames-1:0] vld_q;

  state_e state_q;
  req_t req_q;
  rsp_t rsp_q;
  logic [FrameBits-1:0] hand_q, idx_q, rd_idx_q, hit_idx_q;
  logic [CountBits-1:0] given_q;
  logic [CheckBits-1:0] chk_q;
  logic [CountBits:0] scan_q;
  logic hit_q, rd_pend_q, out_valid_q;
  logic [63:0] tag_rd_q;
  meta_t meta_rd_q;

  logic [FrameBits-1:0] meta_addr;
  logic meta_we;
  meta_t meta_wd;
  logic tag_we;
  logic [FrameBits-1:0] tag_addr;
  logic [63:0] tag_wd;

  assign in_ready_o = (state_q == S_IDLE) && !out_valid_q;
  assign out_valid_o = out_valid_q;
  assign out_data_o = rsp_q;

  always_ff @(posedge clk_i) begin
    if (tag_we) begin
      tag_mem[tag_addr] <= tag_wd;
    end
    tag_rd_q <= tag_mem[tag_addr];
    if (meta_we) begin
      meta_mem[meta_addr] <= meta_wd;
    end
    meta_rd_q <= meta_mem[meta_addr];
  end

  logic scan_done;
  logic match;
  meta_t cur;
  assign scan_done = (scan_q == (CountBits+1)'(PoolFrames));
  assign match = rd_pend_q && vld_q[rd_idx_q] &&
                 (tag_rd_q == {req_q.rel_number, req_q.block_number});
  assign cur = vld_q[idx_q] ? meta_rd_q : '0;

  always_comb begin
    tag_we = 1'b0;
    tag_addr = scan_q[FrameBits-1:0];
    tag_wd = {req_q.rel_number, req_q.block_number};
    meta_we = 1'b0;
    meta_addr = idx_q;
    meta_wd = cur;
    unique case (state_q)
      S_UPD: begin
        meta_we = 1'b1;
        if (req_q.action == ACT_UNPIN) begin
          if (cur.pins != '0) meta_wd.pins = cur.pins - 1'b1;
          if (req_q.set_dirty) meta_wd.dirty = 1'b1;
        end else begin
          if (cur.pins != '1) meta_wd.pins = cur.pins + 1'b1;
          if (cur.usage < UsageCap) meta_wd.usage = cur.usage + 3'd1;
        end
      end
      S_SWP: begin
        meta_addr = hand_q;
        if (rd_pend_q && cur.pins == '0) begin
          meta_addr = idx_q;
          if (cur.usage == '0) begin
            meta_we = 1'b1;
            meta_wd = '{valid: 1'b1, dirty: 1'b0, pins: PinBits'(1), usage: 3'd1};
            tag_we = 1'b1;
            tag_addr = idx_q;
          end else begin
            meta_we = 1'b1;
            meta_wd.usage = cur.usage - 3'd1;
          end
        end
      end
      S_META: begin
        meta_addr = hit_idx_q;
        if (!hit_q && given_q != CountBits'(PoolFrames)) begin
          meta_we = 1'b1;
          meta_addr = given_q[FrameBits-1:0];
          meta_wd = '{valid: 1'b1, dirty: 1'b0, pins: PinBits'(1), usage: 3'd1};
          tag_we = 1'b1;
          tag_addr = given_q[FrameBits-1:0];
        end
      end
      S_VIC: begin
        tag_addr = idx_q;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      vld_q <= '0;
      hand_q <= '0;
      given_q <= '0;
      out_valid_q <= 1'b0;
      rd_pend_q <= 1'b0;
      hit_q <= 1'b0;
      scan_q <= '0;
      chk_q <= '0;
      idx_q <= '0;
      rd_idx_q <= '0;
      hit_idx_q <= '0;
    end else begin
      if (out_valid_q && out_ready_i) out_valid_q <= 1'b0;
      unique case (state_q)
        S_IDLE: begin
          if (in_valid_i && in_ready_o) begin
            req_q <= in_data_i;
            scan_q <= '0;
            hit_q <= 1'b0;
            rd_pend_q <= 1'b0;
            state_q <= S_SCAN;
          end
        end
        S_SCAN: begin
          if (match && !hit_q) begin
            hit_q <= 1'b1;
            hit_idx_q <= rd_idx_q;
          end
          rd_pend_q <= !scan_done;
          rd_idx_q <= scan_q[FrameBits-1:0];
          if (!scan_done) scan_q <= scan_q + 1'b1;
          else if (!rd_pend_q) state_q <= S_META;
        end
        S_META: begin
          rd_pend_q <= 1'b0;
          if (hit_q) begin
            idx_q <= hit_idx_q;
            state_q <= S_UPD;
            rsp_q <= '{frame: 6'(hit_idx_q),
                       status: (req_q.action == ACT_UNPIN) ? ST_UNPINNED : ST_HIT,
                       default: '0};
          end else if (req_q.action == ACT_UNPIN) begin
            rsp_q <= '{status: ST_UNKNOWN, default: '0};
            state_q <= S_OUT;
          end else if (given_q != CountBits'(PoolFrames)) begin
            vld_q[given_q[FrameBits-1:0]] <= 1'b1;
            given_q <= given_q + 1'b1;
            rsp_q <= '{frame: 6'(given_q), status: ST_MISS_FREE, load_needed: 1'b1,
                       default: '0};
            state_q <= S_OUT;
          end else begin
            rsp_q <= '0;
            chk_q <= '0;
            state_q <= S_SWP;
          end
        end
        S_UPD: state_q <= S_OUT;
        S_SWP: begin
          if (rd_pend_q) begin
            if (cur.pins == '0 && cur.usage == '0) begin
              rsp_q <= '{frame: 6'(idx_q), status: ST_MISS_EVICT, load_needed: 1'b1,
                         writeback_needed: cur.dirty, default: '0};
              state_q <= S_VIC;
            end else if (chk_q == CheckBits'(MaxChecks)) begin
              rsp_q.status <= ST_EXHAUSTED;
              state_q <= S_OUT;
            end
            rd_pend_q <= 1'b0;
          end else begin
            idx_q <= hand_q;
            hand_q <= (hand_q == FrameBits'(PoolFrames - 1)) ? '0 : hand_q + 1'b1;
            chk_q <= chk_q + 1'b1;
            rd_pend_q <= 1'b1;
          end
        end
        S_VIC: begin
          if (rsp_q.writeback_needed) begin
            {rsp_q.writeback_rel, rsp_q.writeback_block} <= tag_rd_q;
          end
          state_q <= S_OUT;
        end
        S_OUT: begin
          out_valid_q <= 1'b1;
          state_q <= S_IDLE;
        end
        default: state_q <= S_IDLE;
      endcase
    end
  end

`ifndef SYNTHESIS
  a_ready_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_ready_o |-> state_q == S_IDLE)
    else $error("ready outside idle");
  a_given_max: assert property (@(posedge clk_i) disable iff (!rst_ni)
    given_q <= CountBits'(PoolFrames))
    else $error("handout count overflow");
  a_out_once: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == S_OUT |=> out_valid_q)
    else $error("result lost");
  a_chk_max: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == S_SWP |-> chk_q <= CheckBits'(MaxChecks))
    else $error("sweep overran");
`endif
endmodule
`default_nettype wire
